/* rtl/lookat_view_matrix_macros.svh */
// Assertion macros for the look-at view matrix block.
// Included by the top-level RTL file, which carries the concurrent assertions.
`ifndef LOOKAT_VIEW_MATRIX_MACROS_SVH
`define LOOKAT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/lvm_pkg.sv */
// Shared constants and helpers for the look-at view matrix block.
// No dependencies; imported by lvm_isqrt, lvm_norm, the top level and the testbench.
package lvm_pkg;

	localparam int FRAC_BITS_DEF = 16;
	// square-root steps, one per pipeline stage
	localparam int ISQ_STEPS = 32;
	// magnitude search sub-stages and the normalised magnitude width
	localparam int SRCH_STAGES = 6;
	localparam int MAG_W = 30;
	localparam int MAG_TOP = 29;
	// busy hold after each accepted word (three rows per word)
	localparam logic [1:0] ITEM_GAP = 2'd2;

	localparam logic [1:0] ROW_RIGHT = 2'd0;
	localparam logic [1:0] ROW_UP = 2'd1;
	localparam logic [1:0] ROW_DIR = 2'd2;

	// normaliser latency: abs, search, shift, square, sum, root, prep, divide, out
	function automatic int norm_lat(input int frac);
		return 1 + SRCH_STAGES + 1 + 1 + 1 + ISQ_STEPS + 1 + (frac + 1) + 1;
	endfunction

	// round half away from zero while dropping sh low bits (sh >= 1)
	function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
			input int sh);
		logic [63:0] mag;
		mag = v[63] ? -v : v;
		mag = (mag + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

endpackage

/* rtl/lvm_delay.sv */
// Delay line for side data with a reset valid bit travelling alongside.
// Depends on nothing.
module lvm_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vin,
	input  logic [WIDTH-1:0] din,
	output logic             vout,
	output logic [WIDTH-1:0] dout
);

	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] dat_q [DEPTH];

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q[0] <= vin;
			for (int i = 1; i < DEPTH; i++) vld_q[i] <= vld_q[i-1];
		end
	end

	// advance the data
	always_ff @(posedge clk) begin
		dat_q[0] <= din;
		for (int i = 1; i < DEPTH; i++) dat_q[i] <= dat_q[i-1];
	end

	assign vout = vld_q[DEPTH-1];
	assign dout = dat_q[DEPTH-1];

endmodule

/* rtl/lvm_isqrt.sv */
// Pipelined floor integer square root, one root bit (one radicand bit pair) per stage.
// Depends on lvm_pkg.
module lvm_isqrt (
	input  logic        clk,
	input  logic [63:0] radicand,
	output logic [31:0] root
);
	import lvm_pkg::*;

	logic [63:0] rem_q [ISQ_STEPS];
	logic [63:0] res_q [ISQ_STEPS];

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
		localparam int PK = (k == 0) ? 0 : k - 1;
		logic [63:0] rem_in, res_in, bitv;
		assign rem_in = (k == 0) ? radicand : rem_q[PK];
		assign res_in = (k == 0) ? 64'd0 : res_q[PK];
		assign bitv = 64'd1 << (62 - 2 * k);

		// try the next bit of the root
		always_ff @(posedge clk) begin
			if (rem_in >= res_in + bitv) begin
				rem_q[k] <= rem_in - (res_in + bitv);
				res_q[k] <= (res_in >> 1) + bitv;
			end else begin
				rem_q[k] <= rem_in;
				res_q[k] <= res_in >> 1;
			end
		end
	end

	assign root = res_q[ISQ_STEPS-1][31:0];

endmodule

/* rtl/lvm_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the quotient must fit QW bits.
module lvm_div #(
	parameter int QW = 17,
	parameter int NW = 48,
	parameter int DW = 31
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo
);

	logic [NW-1:0] rem_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar i = 0; i < QW; i++) begin : g_bit
		localparam int PI = (i == 0) ? 0 : i - 1;
		localparam int B = QW - 1 - i;
		logic [NW-1:0] rem_in, trial;
		logic [DW-1:0] den_in;
		logic [QW-1:0] quo_in;
		assign rem_in = (i == 0) ? num : rem_q[PI];
		assign den_in = (i == 0) ? den : den_q[PI];
		assign quo_in = (i == 0) ? '0 : quo_q[PI];
		assign trial = NW'(den_in) << B;

		// subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			den_q[i] <= den_in;
			if (rem_in >= trial) begin
				rem_q[i] <= rem_in - trial;
				quo_q[i] <= quo_in | (QW'(1) << B);
			end else begin
				rem_q[i] <= rem_in;
				quo_q[i] <= quo_in;
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

/* rtl/lvm_norm.sv */
// Pipelined 3-vector normaliser: scale, sum of squares, root, divide.
// Depends on lvm_pkg, lvm_delay, lvm_isqrt and lvm_div.
module lvm_norm #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF,
	parameter int IN_W = 33
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [2:0][IN_W-1:0]       vec,
	output logic                       out_valid,
	output logic                       nonzero,
	output logic [2:0][FRAC_BITS+1:0]  unit
);
	import lvm_pkg::*;

	localparam int AW = FRAC_BITS + 2;
	localparam int QW = FRAC_BITS + 1;
	localparam int NW = FRAC_BITS + 32;

	// stage 1: magnitudes and their maximum
	logic [2:0][IN_W-1:0] mag_c;
	logic [IN_W-1:0]      max_c;
	logic [2:0][IN_W-1:0] mag_s1;
	logic [2:0]           neg_s1;
	logic [IN_W-1:0]      max_s1;
	logic                 vld_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) mag_c[i] = vec[i][IN_W-1] ? -vec[i] : vec[i];
		max_c = mag_c[0];
		if (mag_c[1] > max_c) max_c = mag_c[1];
		if (mag_c[2] > max_c) max_c = mag_c[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_c;
		max_s1 <= max_c;
		for (int i = 0; i < 3; i++) neg_s1[i] <= vec[i][IN_W-1];
	end

	// stage 2: binary search for the top set bit of the maximum
	logic [63:0] srch_t_s2 [SRCH_STAGES];
	logic [5:0]  srch_p_s2 [SRCH_STAGES];

	for (genvar k = 0; k < SRCH_STAGES; k++) begin : g_srch
		localparam int PK = (k == 0) ? 0 : k - 1;
		localparam int STEP = 32 >> k;
		logic [63:0] t_in;
		logic [5:0]  p_in;
		assign t_in = (k == 0) ? 64'(max_s1) : srch_t_s2[PK];
		assign p_in = (k == 0) ? 6'd0 : srch_p_s2[PK];
		always_ff @(posedge clk) begin
			if ((t_in >> STEP) != 64'd0) begin
				srch_t_s2[k] <= t_in >> STEP;
				srch_p_s2[k] <= p_in + 6'(STEP);
			end else begin
				srch_t_s2[k] <= t_in;
				srch_p_s2[k] <= p_in;
			end
		end
	end

	logic                 vld_srch;
	logic [2:0][IN_W-1:0] mag_srch;
	logic [2:0]           neg_srch;
	logic                 nz_srch;

	lvm_delay #(.WIDTH(3 * IN_W + 4), .DEPTH(SRCH_STAGES)) u_dly_srch (
		.clk   (clk),
		.arst_n(arst_n),
		.vin   (vld_s1),
		.din   ({mag_s1, neg_s1, max_s1 != '0}),
		.vout  (vld_srch),
		.dout  ({mag_srch, neg_srch, nz_srch})
	);

	// stage 3: bring the largest magnitude into [2^29, 2^30)
	logic [5:0]            msb;
	logic [2:0][MAG_W-1:0] mag_s3;
	logic [2:0]            neg_s3;
	logic                  nz_s3;
	logic                  vld_s3;

	assign msb = srch_p_s2[SRCH_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_srch;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (msb >= 6'(MAG_TOP))
				mag_s3[i] <= MAG_W'(64'(mag_srch[i]) >> (msb - 6'(MAG_TOP)));
			else
				mag_s3[i] <= MAG_W'(64'(mag_srch[i]) << (6'(MAG_TOP) - msb));
		end
		neg_s3 <= neg_srch;
		nz_s3 <= nz_srch;
	end

	// stages 4 and 5: squares, then their sum
	logic [2:0][2*MAG_W-1:0] sq_s4;
	logic [2*MAG_W+1:0]      sum_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) sq_s4[i] <= mag_s3[i] * mag_s3[i];
		sum_s5 <= (2*MAG_W+2)'(sq_s4[0]) + (2*MAG_W+2)'(sq_s4[1])
			+ (2*MAG_W+2)'(sq_s4[2]);
	end

	logic [31:0] root;

	lvm_isqrt u_isqrt (
		.clk     (clk),
		.radicand(64'(sum_s5)),
		.root    (root)
	);

	logic                  vld_rt;
	logic [2:0][MAG_W-1:0] mag_rt;
	logic [2:0]            neg_rt;
	logic                  nz_rt;

	lvm_delay #(.WIDTH(3 * MAG_W + 4), .DEPTH(ISQ_STEPS + 2)) u_dly_rt (
		.clk   (clk),
		.arst_n(arst_n),
		.vin   (vld_s3),
		.din   ({mag_s3, neg_s3, nz_s3}),
		.vout  (vld_rt),
		.dout  ({mag_rt, neg_rt, nz_rt})
	);

	// stage 6: rounded numerators over the length
	logic [2:0][NW-1:0] num_s6;
	logic [30:0]        den_s6;
	logic [2:0]         neg_s6;
	logic               nz_s6;
	logic               vld_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_rt;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			num_s6[i] <= (NW'(mag_rt[i]) << FRAC_BITS) + NW'(root[31:1]);
		den_s6 <= root[30:0];
		neg_s6 <= neg_rt;
		nz_s6 <= nz_rt;
	end

	logic [2:0][QW-1:0] quo;

	for (genvar i = 0; i < 3; i++) begin : g_div
		lvm_div #(.QW(QW), .NW(NW), .DW(31)) u_div (
			.clk(clk),
			.num(num_s6[i]),
			.den(den_s6),
			.quo(quo[i])
		);
	end

	logic       vld_dv;
	logic [2:0] neg_dv;
	logic       nz_dv;

	lvm_delay #(.WIDTH(4), .DEPTH(QW)) u_dly_dv (
		.clk   (clk),
		.arst_n(arst_n),
		.vin   (vld_s6),
		.din   ({neg_s6, nz_s6}),
		.vout  (vld_dv),
		.dout  ({neg_dv, nz_dv})
	);

	// stage 7: restore the signs
	logic [2:0][AW-1:0] unit_s7;
	logic               nz_s7;
	logic               vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= vld_dv;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			unit_s7[i] <= neg_dv[i] ? -AW'(quo[i]) : AW'(quo[i]);
		nz_s7 <= nz_dv;
	end

	assign out_valid = vld_s7;
	assign nonzero = nz_s7;
	assign unit = unit_s7;

endmodule

/* rtl/lookat_view_matrix.sv */
// Top level of the look-at view matrix block.
// Depends on lvm_pkg, lvm_norm, lvm_delay and lookat_view_matrix_macros.svh.
//
// Use:
//   Input channel: a word (eye, target, world up, signed fixed point) is taken
//   at a rising edge where start is high and busy is low. After each accepted
//   word busy stays high while gap_q counts down from ITEM_GAP, a spacing set
//   by the three-row result channel; earlier words may still be in flight.
//   Result channel: each word yields three rows (right, up, dir) on
//   consecutive cycles, each marked by strobe for one cycle. The receiver
//   cannot stall; rows are always taken when strobed.
//   Internally the datapath is a free-running pipeline: two normalisers in
//   parallel, cross product, a third normaliser, the second cross product
//   and the dot products with the eye, each root and divide bit in a stage
//   of its own. L = FRAC_BITS + 45 is the normaliser depth.
//   Reset: clears all valid bits and the row sequencer; no rows are emitted
//   until a word is accepted. A zero-length vector flags degenerate and
//   zeroes the axes and translations of all three rows.
module lookat_view_matrix #(
	parameter int FRAC_BITS = lvm_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] world_up_x,
	input  logic signed [31:0] world_up_y,
	input  logic signed [31:0] world_up_z,
	output logic               strobe,
	output logic [1:0]         row_index,
	output logic signed [17:0] axis_x,
	output logic signed [17:0] axis_y,
	output logic signed [17:0] axis_z,
	output logic signed [31:0] translation,
	output logic               degenerate,
	output logic               last_row
);
	import lvm_pkg::*;

	`include "lookat_view_matrix_macros.svh"

	localparam int AW = FRAC_BITS + 2;
	localparam int CW = 2 * AW + 1;
	localparam int PW = AW + 32;
	localparam int SW = AW + 34;
	localparam int L = norm_lat(FRAC_BITS);

	logic       accept;
	logic [1:0] gap_q;

	assign accept = start && !busy;
	assign busy = (gap_q != 2'd0);

	// hold off the next word for the length of one row burst
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= 2'd0;
		else if (accept) gap_q <= ITEM_GAP;
		else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
	end

	// stage 1: capture the word and form eye - target
	logic [2:0][32:0] d_s1;
	logic [2:0][31:0] w_s1;
	logic [2:0][31:0] eye_s1;
	logic             vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= 33'(eye_x) - 33'(target_x);
		d_s1[1] <= 33'(eye_y) - 33'(target_y);
		d_s1[2] <= 33'(eye_z) - 33'(target_z);
		w_s1 <= {world_up_z, world_up_y, world_up_x};
		eye_s1 <= {eye_z, eye_y, eye_x};
	end

	// normalise dir and world up side by side
	logic               vld_n1, nz_d, nz_w;
	logic [2:0][AW-1:0] dir_n1, wn_n1;
	logic [2:0][31:0]   eye_n1;

	lvm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(33)) u_norm_dir (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s1), .vec(d_s1),
		.out_valid(vld_n1), .nonzero(nz_d), .unit(dir_n1)
	);

	lvm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(32)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s1), .vec(w_s1),
		.out_valid(), .nonzero(nz_w), .unit(wn_n1)
	);

	lvm_delay #(.WIDTH(96), .DEPTH(L)) u_dly_eye1 (
		.clk(clk), .arst_n(arst_n), .vin(vld_s1), .din(eye_s1),
		.vout(), .dout(eye_n1)
	);

	// stages 2 and 3: cross(world up, dir)
	logic signed [2*AW-1:0] ca_s2 [3];
	logic signed [2*AW-1:0] cb_s2 [3];
	logic [2:0][AW-1:0]     dir_s2, dir_s3;
	logic [2:0][31:0]       eye_s2, eye_s3;
	logic                   ok_s2, ok_s3, vld_s2, vld_s3;
	logic [2:0][CW-1:0]     c_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_n1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ca_s2[i] <= $signed(wn_n1[(i+1)%3]) * $signed(dir_n1[(i+2)%3]);
			cb_s2[i] <= $signed(wn_n1[(i+2)%3]) * $signed(dir_n1[(i+1)%3]);
			c_s3[i] <= CW'(ca_s2[i]) - CW'(cb_s2[i]);
		end
		dir_s2 <= dir_n1;
		eye_s2 <= eye_n1;
		ok_s2 <= nz_d && nz_w;
		dir_s3 <= dir_s2;
		eye_s3 <= eye_s2;
		ok_s3 <= ok_s2;
	end

	// normalise the right axis, carrying dir and eye alongside
	logic               vld_n2, nz_c, ok_n2;
	logic [2:0][AW-1:0] right_n2, dir_n2;
	logic [2:0][31:0]   eye_n2;

	lvm_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(CW)) u_norm_right (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s3), .vec(c_s3),
		.out_valid(vld_n2), .nonzero(nz_c), .unit(right_n2)
	);

	lvm_delay #(.WIDTH(3 * AW + 97), .DEPTH(L)) u_dly_eye2 (
		.clk(clk), .arst_n(arst_n), .vin(vld_s3), .din({dir_s3, eye_s3, ok_s3}),
		.vout(), .dout({dir_n2, eye_n2, ok_n2})
	);

	// stages 4 to 6: up = cross(dir, right), rounded and clamped
	logic signed [2*AW-1:0] ua_s4 [3];
	logic signed [2*AW-1:0] ub_s4 [3];
	logic signed [CW-1:0]   u_s5 [3];
	logic [2:0][AW-1:0]     ax_s4 [2];
	logic [2:0][AW-1:0]     ax_s5 [2];
	logic [2:0][AW-1:0]     ax_s6 [3];
	logic [2:0][31:0]       eye_s4, eye_s5, eye_s6;
	logic                   ok_s4, ok_s5, ok_s6;
	logic                   vld_s4, vld_s5, vld_s6;
	logic signed [63:0]     ur_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= vld_n2;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ur_c[i] = shr_round(64'(u_s5[i]), FRAC_BITS);
			if (ur_c[i] > (64'sd1 <<< FRAC_BITS)) ur_c[i] = 64'sd1 <<< FRAC_BITS;
			if (ur_c[i] < -(64'sd1 <<< FRAC_BITS)) ur_c[i] = -(64'sd1 <<< FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ua_s4[i] <= $signed(dir_n2[(i+1)%3]) * $signed(right_n2[(i+2)%3]);
			ub_s4[i] <= $signed(dir_n2[(i+2)%3]) * $signed(right_n2[(i+1)%3]);
			u_s5[i] <= CW'(ua_s4[i]) - CW'(ub_s4[i]);
			ax_s6[1][i] <= AW'(ur_c[i]);
		end
		ax_s4[0] <= right_n2;
		ax_s4[1] <= dir_n2;
		ax_s5 <= ax_s4;
		ax_s6[0] <= ax_s5[0];
		ax_s6[2] <= ax_s5[1];
		eye_s4 <= eye_n2;
		eye_s5 <= eye_s4;
		eye_s6 <= eye_s5;
		ok_s4 <= ok_n2 && nz_c;
		ok_s5 <= ok_s4;
		ok_s6 <= ok_s5;
	end

	// stages 7 to 9: translations, then mask a degenerate word
	logic signed [PW-1:0] dp_s7 [3][3];
	logic signed [SW-1:0] ds_s8 [3];
	logic [2:0][AW-1:0]   ax_s7 [3];
	logic [2:0][AW-1:0]   ax_s8 [3];
	logic signed [17:0]   ax_s9 [3][3];
	logic signed [31:0]   tr_s9 [3];
	logic                 ok_s7, ok_s8, ok_s9;
	logic                 vld_s7, vld_s8, vld_s9;
	logic signed [63:0]   tr_c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tr_c[r] = -shr_round(64'(ds_s8[r]), FRAC_BITS);
			if (tr_c[r] > 64'sh7FFFFFFF) tr_c[r] = 64'sh7FFFFFFF;
			if (tr_c[r] < -64'sh80000000) tr_c[r] = -64'sh80000000;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 3; i++) begin
				dp_s7[r][i] <= $signed(ax_s6[r][i]) * $signed(eye_s6[i]);
				ax_s9[r][i] <= ok_s8 ? 18'($signed(ax_s8[r][i])) : 18'sd0;
			end
			ds_s8[r] <= SW'(dp_s7[r][0]) + SW'(dp_s7[r][1]) + SW'(dp_s7[r][2]);
			tr_s9[r] <= ok_s8 ? 32'(tr_c[r]) : 32'sd0;
		end
		ax_s7 <= ax_s6;
		ax_s8 <= ax_s7;
		ok_s7 <= ok_s6;
		ok_s8 <= ok_s7;
		ok_s9 <= ok_s8;
	end

	// row sequencer: show row 0 on load, hold rows 1 and 2 for later
	logic [1:0]         rows_q;
	logic signed [17:0] buf_ax_q [2][3];
	logic signed [31:0] buf_tr_q [2];
	logic               deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
			rows_q <= 2'd0;
		end else if (vld_s9) begin
			strobe <= 1'b1;
			rows_q <= 2'd2;
		end else if (rows_q != 2'd0) begin
			strobe <= 1'b1;
			rows_q <= rows_q - 2'd1;
		end else begin
			strobe <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s9) begin
			row_index <= ROW_RIGHT;
			axis_x <= ax_s9[0][0];
			axis_y <= ax_s9[0][1];
			axis_z <= ax_s9[0][2];
			translation <= tr_s9[0];
			degenerate <= !ok_s9;
			last_row <= 1'b0;
			deg_q <= !ok_s9;
			for (int r = 0; r < 2; r++) begin
				buf_tr_q[r] <= tr_s9[r+1];
				for (int i = 0; i < 3; i++) buf_ax_q[r][i] <= ax_s9[r+1][i];
			end
		end else if (rows_q != 2'd0) begin
			row_index <= (rows_q == 2'd2) ? ROW_UP : ROW_DIR;
			axis_x <= buf_ax_q[rows_q == 2'd2 ? 0 : 1][0];
			axis_y <= buf_ax_q[rows_q == 2'd2 ? 0 : 1][1];
			axis_z <= buf_ax_q[rows_q == 2'd2 ? 0 : 1][2];
			translation <= buf_tr_q[rows_q == 2'd2 ? 0 : 1];
			degenerate <= deg_q;
			last_row <= (rows_q == 2'd1);
		end
	end

	`LVM_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, busy, "busy not raised after accept")
	`LVM_ASSERT_NEXT(a_up_follows_right, clk, arst_n, strobe && row_index == ROW_RIGHT, strobe && row_index == ROW_UP, "up row missing after right row")
	`LVM_ASSERT_NEXT(a_dir_follows_up, clk, arst_n, strobe && row_index == ROW_UP, strobe && last_row && row_index == ROW_DIR, "dir row missing after up row")
	`LVM_ASSERT_NOW(a_degenerate_zero, clk, arst_n, strobe && degenerate, axis_x == 18'sd0 && axis_y == 18'sd0 && axis_z == 18'sd0 && translation == 32'sd0, "degenerate row not zeroed")

endmodule

/* sim/tb_lookat_view_matrix.sv */
`timescale 1ns / 1ps
// Testbench for the look-at view matrix block: drives eye/target/up words and
// checks every emitted row against a fixed-point predictor. Depends on lvm_pkg.
module tb_lookat_view_matrix;
	import lvm_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int WATCH_LIMIT = 5000;

	typedef struct {
		logic [1:0]         row;
		logic signed [17:0] ax, ay, az;
		logic signed [31:0] trans;
		logic               degen, last;
	} row_t;

	class row_scoreboard;
		row_t pending[$];
		int   errors;

		function automatic longint round_away(longint v, int sh);
			longint m;
			m = v < 0 ? -v : v;
			m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
			return v < 0 ? -m : m;
		endfunction

		function automatic bit unit_vec(longint v[3], output longint o[3]);
			longint unsigned mg[3], m, sum, len, res, bitv, n, q;
			m = 0;
			for (int i = 0; i < 3; i++) begin
				mg[i] = v[i] < 0 ? -v[i] : v[i];
				if (mg[i] > m) m = mg[i];
			end
			if (m == 0) return 0;
			while (m >= (64'd1 << 30)) begin
				for (int i = 0; i < 3; i++) mg[i] >>= 1;
				m >>= 1;
			end
			while (m < (64'd1 << 29)) begin
				for (int i = 0; i < 3; i++) mg[i] <<= 1;
				m <<= 1;
			end
			sum = 0;
			for (int i = 0; i < 3; i++) sum += mg[i] * mg[i];
			// floor square root, bit by bit
			n = sum; res = 0; bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else res >>= 1;
				bitv >>= 2;
			end
			len = res;
			for (int i = 0; i < 3; i++) begin
				q = ((mg[i] << FB) + (len >> 1)) / len;
				o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
			end
			return 1;
		endfunction

		function automatic void cross3(longint a[3], longint b[3], output longint c[3]);
			c[0] = a[1] * b[2] - a[2] * b[1];
			c[1] = a[2] * b[0] - a[0] * b[2];
			c[2] = a[0] * b[1] - a[1] * b[0];
		endfunction

		// note one accepted word: push its three expected rows
		function void note_word(logic signed [31:0] w[9]);
			longint eye[3], d[3], up[3], wn[3], c[3], ax[3][3], u, dot, t;
			bit ok;
			row_t r;
			for (int i = 0; i < 3; i++) begin
				eye[i] = w[i];
				d[i] = longint'(w[i]) - longint'(w[3 + i]);
				up[i] = w[6 + i];
			end
			ok = unit_vec(d, ax[2]);
			if (ok) ok = unit_vec(up, wn);
			if (ok) begin
				cross3(wn, ax[2], c);
				ok = unit_vec(c, ax[0]);
			end
			if (ok) begin
				cross3(ax[2], ax[0], c);
				for (int i = 0; i < 3; i++) begin
					u = round_away(c[i], FB);
					if (u > (64'sd1 <<< FB)) u = 64'sd1 <<< FB;
					if (u < -(64'sd1 <<< FB)) u = -(64'sd1 <<< FB);
					ax[1][i] = u;
				end
			end
			for (int k = 0; k < 3; k++) begin
				t = 0;
				r.row = k[1:0];
				r.ax = 0; r.ay = 0; r.az = 0;
				if (ok) begin
					dot = 0;
					for (int i = 0; i < 3; i++) dot += ax[k][i] * eye[i];
					t = -round_away(dot, FB);
					if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
					if (t < -64'sh80000000) t = -64'sh80000000;
					r.ax = ax[k][0][17:0]; r.ay = ax[k][1][17:0]; r.az = ax[k][2][17:0];
				end
				r.trans = t[31:0];
				r.degen = !ok;
				r.last = (k == 2);
				pending.push_back(r);
			end
		endfunction

		function void report(string what, longint got, longint want);
			errors++;
			$display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
		endfunction

		// check one strobed row against the oldest expectation
		function void check_row(row_t g);
			row_t e;
			if (pending.size() == 0) begin
				report("unexpected row", g.row, -1);
				return;
			end
			e = pending.pop_front();
			if (g.row !== e.row) report("row_index", g.row, e.row);
			if (g.ax !== e.ax) report("axis_x", g.ax, e.ax);
			if (g.ay !== e.ay) report("axis_y", g.ay, e.ay);
			if (g.az !== e.az) report("axis_z", g.az, e.az);
			if (g.trans !== e.trans) report("translation", g.trans, e.trans);
			if (g.degen !== e.degen) report("degenerate", g.degen, e.degen);
			if (g.last !== e.last) report("last_row", g.last, e.last);
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0;
	logic busy, strobe, degenerate, last_row;
	logic signed [31:0] wv[9];
	logic [1:0] row_index;
	logic signed [17:0] axis_x, axis_y, axis_z;
	logic signed [31:0] translation;
	row_scoreboard sb = new();
	int idle_cycles = 0;

	initial for (int i = 0; i < 9; i++) wv[i] = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	lookat_view_matrix i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eye_x(wv[0]), .eye_y(wv[1]), .eye_z(wv[2]),
		.target_x(wv[3]), .target_y(wv[4]), .target_z(wv[5]),
		.world_up_x(wv[6]), .world_up_y(wv[7]), .world_up_z(wv[8]),
		.strobe(strobe), .row_index(row_index), .axis_x(axis_x), .axis_y(axis_y),
		.axis_z(axis_z), .translation(translation), .degenerate(degenerate),
		.last_row(last_row)
	);

	// take rows and count cycles with no handshake
	always @(posedge clk) begin
		row_t g;
		if (arst_n) begin
			if (strobe) begin
				g.row = row_index; g.ax = axis_x; g.ay = axis_y; g.az = axis_z;
				g.trans = translation; g.degen = degenerate; g.last = last_row;
				sb.check_row(g);
			end
			if (strobe || (start && !busy)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCH_LIMIT) begin
				$display("lookat_view_matrix verification failed");
				$finish;
			end
		end
	end

	// present one word, hold until accepted, then idle a random gap
	task automatic send_word(logic signed [31:0] w[9]);
		int gap;
		gap = $urandom_range(9);
		@(posedge clk);
		for (int i = 0; i < 9; i++) wv[i] <= w[i];
		start <= 1;
		do @(posedge clk); while (busy);
		sb.note_word(w);
		if (gap != 0 || $urandom_range(3) == 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rnd_field(int kind);
		case (kind)
			0: return $urandom();
			1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
			2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
			default: return $signed($urandom_range(0, 32'hFFFFFF)) - 32'sh800000;
		endcase
	endfunction

	initial begin
		logic signed [31:0] w[9];
		int kind;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		// extremes
		for (int i = 0; i < 9; i++) w[i] = 32'sh7FFFFFFF;
		w[3] = 32'sh80000000; w[4] = 0; w[7] = 1;
		send_word(w);
		for (int i = 0; i < 9; i++) w[i] = 32'sh80000000;
		w[3] = 32'sh7FFFFFFF; w[6] = 32'sh7FFFFFFF;
		send_word(w);
		// plain camera: eye at z = 5, up along y
		w = '{0, 0, 5 << 16, 0, 0, 0, 0, 1 << 16, 0};
		send_word(w);
		// eye equals target
		w = '{3 << 16, -2, 7, 3 << 16, -2, 7, 0, 1 << 16, 0};
		send_word(w);
		// world up zero
		w = '{1 << 16, 0, 0, 0, 0, 0, 0, 0, 0};
		send_word(w);
		// world up parallel to dir
		w = '{0, 4 << 16, 0, 0, 0, 0, 0, -9 << 16, 0};
		send_word(w);
		// translation saturation with a far eye
		w = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFF0, 32'sh7FFFFFF0,
			32'sh80000000, 1, 0, -1};
		send_word(w);
		for (int i = 0; i < 9; i++) w[i] = 32'shFFFFFFFF;
		w[3] = 0;
		send_word(w);
		// random words; pause until drained at the midpoint
		for (int n = 0; n < 340; n++) begin
			kind = $urandom_range(3);
			for (int i = 0; i < 9; i++)
				w[i] = $urandom_range(7) == 0 ? rnd_field($urandom_range(3)) : rnd_field(kind);
			if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) w[3 + i] = w[i];
			if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) w[6 + i] = w[i] - w[3 + i];
			send_word(w);
			if (n == 170) begin
				@(posedge clk);
				start <= 0;
				wait (sb.pending.size() == 0);
			end
		end
		@(posedge clk);
		start <= 0;
		wait (sb.pending.size() == 0);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("lookat_view_matrix verification clean");
		else $display("lookat_view_matrix verification failed");
		$finish;
	end
endmodule

/* sim.f */
+incdir+rtl
rtl/lvm_pkg.sv
rtl/lvm_delay.sv
rtl/lvm_isqrt.sv
rtl/lvm_div.sv
rtl/lvm_norm.sv
rtl/lookat_view_matrix.sv
sim/tb_lookat_view_matrix.sv
